/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and ignored in reset.
`define SRSI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srsi assertion failed");

// Next-cycle implication, sampled on the rising clock edge and ignored in reset.
`define SRSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srsi assertion failed");

`endif

/* rtl/srsi_pkg.sv */
package srsi_pkg;

  // Width of the window length register and its value after reset.
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd14;
  localparam logic [CFG_W-1:0] WINDOW_MIN = 7'd2;

  // Fixed point results: 16 fraction bits, 65536 stands for full scale.
  localparam int FRAC_BITS = 16;
  localparam int RESULT_W = FRAC_BITS + 1;
  localparam logic [RESULT_W-1:0] FULL_SCALE = 17'h10000;
  localparam int DIV_CNT_W = $clog2(FRAC_BITS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_BITS - 1);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRICE,
    ST_RSI_PREP,
    ST_RSI_DIV,
    ST_RSI_WR,
    ST_RANGE,
    ST_STOCH_PREP,
    ST_STOCH_DIV,
    ST_EMIT
  } state_t;

endpackage

/* rtl/stochastic_rsi_window.sv */
// Channel  | Direction | Handshake            | Payload
// cfg      | in        | cfg_valid/cfg_ready  | cfg_window_length
// in       | in        | in_valid/in_ready    | in_price, in_series_start
// out      | out       | out_valid/out_ready  | out_stoch_value, out_rsi_value,
//          |           |                      | out_flat_window
//
// An item's work is set by the walk of the price ring and of the RSI ring, one
// read a cycle, and by up to two 16-step runs of the one shared restoring divider; the
// second run is skipped when the RSI window is flat. During warm-up an item is only stored,
// or also walks the price ring and stores an RSI value. A new item is taken only in idle.
// Reset (rst_n, synchronous) clears control state only; the history rings are not cleared.
// A finished result waits in the output register while the next transaction is taken.
module stochastic_rsi_window
  import srsi_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_window_length,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic                  in_series_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RESULT_W-1:0]   out_stoch_value,
  output logic [RESULT_W-1:0]   out_rsi_value,
  output logic                  out_flat_window
);

  localparam int SLOTS = MAX_WINDOW + 1;
  localparam int PIDX_W = $clog2(SLOTS);
  localparam int RIDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(2 * MAX_WINDOW + 1);
  localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW + 1);
  localparam int DIV_W = (SUM_W > RESULT_W) ? SUM_W : RESULT_W;
  localparam int WCMP_W = (CNT_W > 32) ? CNT_W : 32;

  // Ring index helpers.
  function automatic logic [PIDX_W-1:0] pdec(input logic [PIDX_W-1:0] a);
    pdec = (a == '0) ? PIDX_W'(SLOTS - 1) : a - PIDX_W'(1);
  endfunction

  function automatic logic [PIDX_W-1:0] pinc(input logic [PIDX_W-1:0] a);
    pinc = (a == PIDX_W'(SLOTS - 1)) ? '0 : a + PIDX_W'(1);
  endfunction

  function automatic logic [RIDX_W-1:0] rdec(input logic [RIDX_W-1:0] a);
    rdec = (a == '0) ? RIDX_W'(MAX_WINDOW - 1) : a - RIDX_W'(1);
  endfunction

  function automatic logic [RIDX_W-1:0] rinc(input logic [RIDX_W-1:0] a);
    rinc = (a == RIDX_W'(MAX_WINDOW - 1)) ? '0 : a + RIDX_W'(1);
  endfunction

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]      wl_r, wl_nxt;
  logic [CNT_W-1:0]      samples_r, samples_nxt;
  logic [PIDX_W-1:0]     wp_r, wp_nxt;
  logic [PIDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [RIDX_W-1:0]     rwp_r, rwp_nxt;
  logic [RIDX_W-1:0]     rrd_ptr_r, rrd_ptr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PRICE_BITS-1:0] prev_r, prev_nxt;
  logic [SUM_W-1:0]      gain_r, gain_nxt;
  logic [SUM_W-1:0]      loss_r, loss_nxt;
  logic [DIV_W-1:0]      div_rem_r, div_rem_nxt;
  logic [DIV_W-1:0]      div_den_r, div_den_nxt;
  logic [FRAC_BITS-1:0]  div_q_r, div_q_nxt;
  logic                  div_full_r, div_full_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [RESULT_W-1:0]   rsi_r, rsi_nxt;
  logic [RESULT_W-1:0]   lo_r, lo_nxt;
  logic [RESULT_W-1:0]   hi_r, hi_nxt;
  logic                  flat_r, flat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0]   out_stoch_r, out_stoch_nxt;
  logic [RESULT_W-1:0]   out_rsi_r, out_rsi_nxt;
  logic                  out_flat_r, out_flat_nxt;

  logic                  cfg_fire;
  logic                  in_fire;
  logic                  out_fire;
  logic [CNT_W-1:0]      win_p;
  logic [CNT_W-1:0]      win_last;
  logic [CNT_W:0]        win_twice;
  logic [CNT_W-1:0]      samples_base;
  logic [CNT_W-1:0]      samples_new;
  logic                  warm_done;

  // Memories and their read ports.
  logic [PRICE_BITS-1:0] price_mem [SLOTS];
  logic [PRICE_BITS-1:0] price_rd_r;
  logic [PIDX_W-1:0]     price_rd_addr;
  logic [RESULT_W-1:0]   rsi_mem [MAX_WINDOW];
  logic [RESULT_W-1:0]   rsi_rd_r;
  logic [RIDX_W-1:0]     rsi_rd_addr;
  logic                  rsi_we;

  // Shared divider step and gain/loss unit.
  logic [DIV_W:0]        div_shift;
  logic [DIV_W:0]        div_sub;
  logic                  div_fits;
  logic                  div_last;
  logic [RESULT_W-1:0]   div_result;
  logic                  price_up;
  logic [PRICE_BITS-1:0] price_diff;
  logic [RESULT_W-1:0]   stoch_val;

  // Handshakes.
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  // Effective window length, clamped to the supported range.
  always_comb begin
    if (wl_r < WINDOW_MIN) begin
      win_p = CNT_W'(WINDOW_MIN);
    end else if (WCMP_W'(wl_r) > WCMP_W'(MAX_WINDOW)) begin
      win_p = CNT_W'(MAX_WINDOW);
    end else begin
      win_p = CNT_W'(wl_r);
    end
  end

  assign win_last  = win_p - CNT_W'(1);
  assign win_twice = {win_p, 1'b0};
  assign warm_done = ({1'b0, samples_r} >= win_twice);

  // Warm-up count for the incoming transaction, saturating.
  assign samples_base = in_series_start ? '0 : samples_r;
  assign samples_new  = (samples_base < CNT_W'(2 * MAX_WINDOW)) ?
                        samples_base + CNT_W'(1) : samples_base;

  // Divider step: shift the remainder and subtract the divisor where it fits.
  assign div_shift  = {div_rem_r, 1'b0};
  assign div_sub    = div_shift - {1'b0, div_den_r};
  assign div_fits   = (div_shift >= {1'b0, div_den_r});
  assign div_last   = (div_cnt_r == DIV_LAST);
  assign div_result = div_full_r ? FULL_SCALE : {1'b0, div_q_r};

  // Absolute difference of two adjacent prices, newer against older.
  assign price_up   = (prev_r > price_rd_r);
  assign price_diff = price_up ? prev_r - price_rd_r : price_rd_r - prev_r;

  assign stoch_val = flat_r ? '0 : div_result;

  // Read addresses: the first read is issued in the cycle that starts each walk.
  assign price_rd_addr = (state_r == ST_IDLE) ? pdec(wp_r) : rd_ptr_r;
  assign rsi_rd_addr   = (state_r == ST_RSI_WR) ? rdec(rwp_r) : rrd_ptr_r;
  assign rsi_we        = (state_r == ST_RSI_WR);

  // Price ring.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      price_mem[wp_r] <= in_price;
    end
    price_rd_r <= price_mem[price_rd_addr];
  end

  // RSI ring.
  always_ff @(posedge clk) begin
    if (rsi_we) begin
      rsi_mem[rwp_r] <= div_result;
    end
    rsi_rd_r <= rsi_mem[rsi_rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (samples_new > win_p)) begin
          state_nxt = ST_PRICE;
        end
      end
      ST_PRICE: begin
        if (cnt_r == win_last) begin
          state_nxt = ST_RSI_PREP;
        end
      end
      ST_RSI_PREP: begin
        state_nxt = ST_RSI_DIV;
      end
      ST_RSI_DIV: begin
        if (div_last) begin
          state_nxt = ST_RSI_WR;
        end
      end
      ST_RSI_WR: begin
        state_nxt = warm_done ? ST_RANGE : ST_IDLE;
      end
      ST_RANGE: begin
        if (cnt_r == win_last) begin
          state_nxt = ST_STOCH_PREP;
        end
      end
      ST_STOCH_PREP: begin
        state_nxt = (hi_r == lo_r) ? ST_EMIT : ST_STOCH_DIV;
      end
      ST_STOCH_DIV: begin
        if (div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    wl_nxt        = wl_r;
    samples_nxt   = samples_r;
    wp_nxt        = wp_r;
    rd_ptr_nxt    = rd_ptr_r;
    rwp_nxt       = rwp_r;
    rrd_ptr_nxt   = rrd_ptr_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    gain_nxt      = gain_r;
    loss_nxt      = loss_r;
    div_rem_nxt   = div_rem_r;
    div_den_nxt   = div_den_r;
    div_q_nxt     = div_q_r;
    div_full_nxt  = div_full_r;
    div_cnt_nxt   = div_cnt_r;
    rsi_nxt       = rsi_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    flat_nxt      = flat_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_stoch_nxt = out_stoch_r;
    out_rsi_nxt   = out_rsi_r;
    out_flat_nxt  = out_flat_r;

    unique case (state_r)
      ST_IDLE: begin
        // A length write restarts warm-up; a price is stored and starts a walk past win_p.
        if (cfg_fire) begin
          wl_nxt      = cfg_window_length;
          samples_nxt = '0;
        end else if (in_fire) begin
          samples_nxt = samples_new;
          wp_nxt      = pinc(wp_r);
          rd_ptr_nxt  = pdec(pdec(wp_r));
          prev_nxt    = in_price;
          gain_nxt    = '0;
          loss_nxt    = '0;
          cnt_nxt     = '0;
        end
      end
      ST_PRICE: begin
        // One price difference per cycle, newest first.
        if (price_up) begin
          gain_nxt = gain_r + SUM_W'(price_diff);
        end else begin
          loss_nxt = loss_r + SUM_W'(price_diff);
        end
        prev_nxt   = price_rd_r;
        rd_ptr_nxt = pdec(rd_ptr_r);
        cnt_nxt    = cnt_r + CNT_W'(1);
      end
      ST_RSI_PREP: begin
        // No losses means full scale, which also covers a zero divisor.
        div_rem_nxt  = DIV_W'(gain_r);
        div_den_nxt  = DIV_W'(gain_r) + DIV_W'(loss_r);
        div_full_nxt = (loss_r == '0);
        div_q_nxt    = '0;
        div_cnt_nxt  = '0;
      end
      ST_RSI_DIV, ST_STOCH_DIV: begin
        div_rem_nxt = div_fits ? div_sub[DIV_W-1:0] : div_shift[DIV_W-1:0];
        div_q_nxt   = {div_q_r[FRAC_BITS-2:0], div_fits};
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
      end
      ST_RSI_WR: begin
        // The new RSI seeds the range search; the ring read continues one back.
        rsi_nxt     = div_result;
        lo_nxt      = div_result;
        hi_nxt      = div_result;
        rwp_nxt     = rinc(rwp_r);
        rrd_ptr_nxt = rdec(rdec(rwp_r));
        cnt_nxt     = CNT_W'(1);
      end
      ST_RANGE: begin
        // One stored RSI value per cycle against the running min and max.
        if (rsi_rd_r < lo_r) begin
          lo_nxt = rsi_rd_r;
        end
        if (rsi_rd_r > hi_r) begin
          hi_nxt = rsi_rd_r;
        end
        rrd_ptr_nxt = rdec(rrd_ptr_r);
        cnt_nxt     = cnt_r + CNT_W'(1);
      end
      ST_STOCH_PREP: begin
        flat_nxt     = (hi_r == lo_r);
        div_rem_nxt  = DIV_W'(rsi_r - lo_r);
        div_den_nxt  = DIV_W'(hi_r - lo_r);
        div_full_nxt = (rsi_r == hi_r);
        div_q_nxt    = '0;
        div_cnt_nxt  = '0;
      end
      ST_EMIT: begin
        // Load the output register once the previous result has been taken.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_stoch_nxt = stoch_val;
          out_rsi_nxt   = rsi_r;
          out_flat_nxt  = flat_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wl_r        <= WINDOW_RESET;
      samples_r   <= '0;
      wp_r        <= '0;
      rwp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      samples_r   <= samples_nxt;
      wp_r        <= wp_nxt;
      rwp_r       <= rwp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    rd_ptr_r    <= rd_ptr_nxt;
    rrd_ptr_r   <= rrd_ptr_nxt;
    cnt_r       <= cnt_nxt;
    prev_r      <= prev_nxt;
    gain_r      <= gain_nxt;
    loss_r      <= loss_nxt;
    div_rem_r   <= div_rem_nxt;
    div_den_r   <= div_den_nxt;
    div_q_r     <= div_q_nxt;
    div_full_r  <= div_full_nxt;
    div_cnt_r   <= div_cnt_nxt;
    rsi_r       <= rsi_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    flat_r      <= flat_nxt;
    out_stoch_r <= out_stoch_nxt;
    out_rsi_r   <= out_rsi_nxt;
    out_flat_r  <= out_flat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_stoch_value = out_stoch_r;
  assign out_rsi_value   = out_rsi_r;
  assign out_flat_window = out_flat_r;

endmodule

/* rtl/srsi_checker.sv */
`include "assert_macros.svh"

module srsi_checker
  import srsi_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                cfg_valid,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [RESULT_W-1:0] out_stoch_value,
  input logic [RESULT_W-1:0] out_rsi_value,
  input logic                out_flat_window
);

  // A stalled result keeps its values until the transaction completes.
  `SRSI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_stoch_value) && $stable(out_rsi_value) && $stable(out_flat_window))

  // Both results stay within full scale.
  `SRSI_ASSERT_NOW(a_out_range, out_valid, (out_stoch_value <= FULL_SCALE) && (out_rsi_value <= FULL_SCALE))

  // A flat RSI window always reports a stochastic value of zero.
  `SRSI_ASSERT_NOW(a_flat_zero, out_valid && out_flat_window, out_stoch_value == '0)

  // A pending window length write holds off price transactions.
  `SRSI_ASSERT_NOW(a_cfg_blocks_in, cfg_valid, !in_ready)

endmodule

bind stochastic_rsi_window srsi_checker u_srsi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_valid       (cfg_valid),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_stoch_value (out_stoch_value),
  .out_rsi_value   (out_rsi_value),
  .out_flat_window (out_flat_window)
);
